@@ src/sssm_pkg.sv @@
// Shared types, codes and segment tables for the seven-segment scan multiplexer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package sssm_pkg;

  localparam logic [1:0] CMD_SET_COUNTER = 2'd0;
  localparam logic [1:0] CMD_SET_RPM     = 2'd1;
  localparam logic [1:0] CMD_SCAN        = 2'd2;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;

  localparam logic CFG_POINT_ENABLE = 1'b0;
  localparam logic CFG_BLINK_ENABLE = 1'b1;

  localparam logic [13:0] VALUE_MAX   = 14'd9999;
  localparam logic [8:0]  BLINK_HALF  = 9'd250;
  localparam logic [7:0]  BLANK_BYTE  = 8'hFF;
  localparam logic [7:0]  POINT_MASK  = 8'hFE;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_COUNTER,
    KIND_RPM,
    KIND_SCAN
  } kind_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        minutes;
    logic [7:0]        seconds;
    logic signed [15:0] rpm_value;
    logic [8:0]        blink_phase;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] common_released;
    logic [1:0] common_driven;
    logic       common_lit;
  } out_item_t;

  typedef struct packed {
    kind_e           kind;
    logic [3:0][7:0] pats;
    logic            dark;
  } entry_t;

  function automatic logic [7:0] counter_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'd129;
      4'd1: s = 8'd243;
      4'd2: s = 8'd73;
      4'd3: s = 8'd97;
      4'd4: s = 8'd51;
      4'd5: s = 8'd37;
      4'd6: s = 8'd5;
      4'd7: s = 8'd241;
      4'd8: s = 8'd1;
      4'd9: s = 8'd33;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rpm_a_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'd3;
      4'd1: s = 8'd111;
      4'd2: s = 8'd133;
      4'd3: s = 8'd37;
      4'd4: s = 8'd105;
      4'd5: s = 8'd49;
      4'd6: s = 8'd17;
      4'd7: s = 8'd103;
      4'd8: s = 8'd1;
      4'd9: s = 8'd33;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rpm_b_seg(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'd17;
      4'd1: s = 8'd221;
      4'd2: s = 8'd41;
      4'd3: s = 8'd137;
      4'd4: s = 8'd197;
      4'd5: s = 8'd131;
      4'd6: s = 8'd3;
      4'd7: s = 8'd217;
      4'd8: s = 8'd1;
      4'd9: s = 8'd129;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/sssm_front.sv @@
// Front end: accepts requests, clamps values, splits digits over two stages
// and pushes classified entries to the queue. Depends on sssm_pkg.
`default_nettype none
module sssm_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sssm_pkg::in_item_t in_data_i,
  input  wire logic              blink_en_i,
  output logic                   push_o,
  output sssm_pkg::entry_t       push_data_o,
  input  wire logic              push_ready_i
);

  function automatic logic [7:0] split10(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  rem;
    p    = 15'(x) * 15'd205;
    tens = p[14:11];
    rem  = x - 7'(tens) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

  logic              adv;
  logic [14:0]       cnt_sum;
  logic [13:0]       val_d;
  sssm_pkg::kind_e   kind_d;
  logic              s1_valid_q, s1_valid_d;
  sssm_pkg::kind_e   s1_kind_q;
  logic [13:0]       s1_val_q;
  logic              s1_dark_q;
  logic [26:0]       prod;
  logic [6:0]        q1;
  logic [13:0]       r_full;
  logic              s2_valid_q;
  sssm_pkg::kind_e   s2_kind_q;
  logic [6:0]        s2_hi_q, s2_lo_q;
  logic              s2_dark_q;
  logic [7:0]        hi_d, lo_d;

  assign adv        = !s2_valid_q || push_ready_i;
  assign in_stall_o = !adv;

  always_comb begin
    cnt_sum = 15'(in_data_i.minutes) * 15'd100 + 15'(in_data_i.seconds);
    if (in_data_i.cmd == sssm_pkg::CMD_SET_COUNTER) begin
      kind_d = sssm_pkg::KIND_COUNTER;
      val_d  = (cnt_sum > 15'(sssm_pkg::VALUE_MAX)) ? sssm_pkg::VALUE_MAX : cnt_sum[13:0];
    end else if (in_data_i.cmd == sssm_pkg::CMD_SET_RPM) begin
      kind_d = sssm_pkg::KIND_RPM;
      if (in_data_i.rpm_value[15]) begin
        val_d = '0;
      end else if (in_data_i.rpm_value[14:0] > 15'(sssm_pkg::VALUE_MAX)) begin
        val_d = sssm_pkg::VALUE_MAX;
      end else begin
        val_d = in_data_i.rpm_value[13:0];
      end
    end else begin
      kind_d = sssm_pkg::KIND_SCAN;
      val_d  = '0;
    end
    s1_valid_d = in_valid_i && (in_data_i.cmd != sssm_pkg::CMD_UNUSED);
  end

  always_comb begin
    prod   = 27'(s1_val_q) * 27'd5243;
    q1     = prod[25:19];
    r_full = s1_val_q - 14'(q1) * 14'd100;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= kind_d;
      s1_val_q  <= val_d;
      s1_dark_q <= blink_en_i && (in_data_i.blink_phase > sssm_pkg::BLINK_HALF);
      s2_kind_q <= s1_kind_q;
      s2_hi_q   <= q1;
      s2_lo_q   <= r_full[6:0];
      s2_dark_q <= s1_dark_q;
    end
  end

  always_comb begin
    hi_d               = split10(s2_hi_q);
    lo_d               = split10(s2_lo_q);
    push_o             = s2_valid_q && push_ready_i;
    push_data_o.kind   = s2_kind_q;
    push_data_o.dark   = s2_dark_q;
    push_data_o.pats   = '0;
    case (s2_kind_q)
      sssm_pkg::KIND_COUNTER: begin
        push_data_o.pats[0] = sssm_pkg::counter_seg(hi_d[7:4]);
        push_data_o.pats[1] = sssm_pkg::counter_seg(hi_d[3:0]);
        push_data_o.pats[2] = sssm_pkg::counter_seg(lo_d[7:4]);
        push_data_o.pats[3] = sssm_pkg::counter_seg(lo_d[3:0]);
      end
      sssm_pkg::KIND_RPM: begin
        push_data_o.pats[0] = sssm_pkg::rpm_a_seg(hi_d[7:4]);
        push_data_o.pats[1] = sssm_pkg::rpm_b_seg(hi_d[3:0]);
        push_data_o.pats[2] = sssm_pkg::rpm_a_seg(lo_d[7:4]);
        push_data_o.pats[3] = sssm_pkg::rpm_b_seg(lo_d[3:0]);
      end
      default: begin
        push_data_o.pats = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/sssm_queue.sv @@
// Short register queue between front and back ends.
// Depends on sssm_pkg for the entry type.
`default_nettype none
module sssm_queue #(
  parameter int Depth = sssm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sssm_pkg::entry_t push_data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output sssm_pkg::entry_t      pop_data_o,
  input  wire logic             pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sssm_pkg::entry_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign ready_o    = count_q != CntW'(Depth);
  assign valid_o    = count_q != '0;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ src/sssm_back.sv @@
// Back end: holds the eight digit patterns and scan position, applies set
// entries and drives the registered scan result. Depends on sssm_pkg.
`default_nettype none
module sssm_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire sssm_pkg::entry_t  q_data_i,
  output logic                   pop_o,
  input  wire logic              point_en_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sssm_pkg::out_item_t    out_data_o
);

  logic [7:0]          patterns_q [8];
  logic [2:0]          pos_q;
  logic                out_valid_q;
  sssm_pkg::out_item_t out_q, out_d;
  logic                is_scan;
  logic [7:0]          pat;

  assign is_scan     = q_data_i.kind == sssm_pkg::KIND_SCAN;
  assign pop_o       = q_valid_i && (!is_scan || !out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    pat                   = patterns_q[pos_q];
    out_d.common_driven   = pos_q[1:0];
    out_d.common_released = pos_q[1:0] + 2'd3;
    if (!pos_q[2]) begin
      out_d.first_byte  = (point_en_i && pos_q[1]) ? (pat & sssm_pkg::POINT_MASK) : pat;
      out_d.second_byte = sssm_pkg::BLANK_BYTE;
      out_d.common_lit  = !q_data_i.dark;
    end else begin
      out_d.first_byte  = sssm_pkg::BLANK_BYTE;
      out_d.second_byte = pat;
      out_d.common_lit  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        patterns_q[i] <= '0;
      end
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        case (q_data_i.kind)
          sssm_pkg::KIND_COUNTER: begin
            for (int i = 0; i < 4; i++) begin
              patterns_q[i] <= q_data_i.pats[i];
            end
          end
          sssm_pkg::KIND_RPM: begin
            for (int i = 0; i < 4; i++) begin
              patterns_q[i+4] <= q_data_i.pats[i];
            end
          end
          sssm_pkg::KIND_SCAN: begin
            pos_q <= pos_q + 3'd1;
          end
          default: begin
          end
        endcase
      end
      if (pop_o && is_scan) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_scan) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

@@ src/seven_segment_scan_multiplexer_core.sv @@
// Top level of the seven-segment scan multiplexer: configuration registers,
// front end, queue and back end. Depends on sssm_pkg and the sssm_* modules.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/in_stall_o   | sssm_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | sssm_pkg::out_item_t
//   cfg     | input     | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; an accepted scan passes the front-end stages,
// the queue slot and the result register before its result is valid.
// Set and unused requests yield no result; unused ones are dropped at the front.
// Reset clears the digit patterns, scan position, queue and both enables.
// A stalled output holds the result register; the queue then fills and the
// front raises in_stall_o once its last stage cannot drain.
`default_nettype none
module seven_segment_scan_multiplexer_core #(
  parameter int QueueDepth = sssm_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sssm_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sssm_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic                cfg_data_i
);

  logic             point_en_q, blink_en_q;
  logic             push, push_ready, q_valid, pop;
  sssm_pkg::entry_t push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_en_q <= 1'b0;
      blink_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sssm_pkg::CFG_POINT_ENABLE) begin
        point_en_q <= cfg_data_i;
      end
      if (cfg_idx_i == sssm_pkg::CFG_BLINK_ENABLE) begin
        blink_en_q <= cfg_data_i;
      end
    end
  end

  sssm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .blink_en_i   (blink_en_q),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sssm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (push_ready),
    .valid_o     (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (pop)
  );

  sssm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .point_en_i  (point_en_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ src/sssm_checker.sv @@
// Port-level checks for the seven-segment scan multiplexer, bound to the top.
// Depends on sssm_pkg and seven_segment_scan_multiplexer_core.
`default_nettype none
module sssm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire sssm_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_common_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.common_released == 2'(out_data_o.common_driven + 2'd3))
    else $error("released common does not precede driven common");

  a_dark_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.common_lit) |-> out_data_o.second_byte == sssm_pkg::BLANK_BYTE)
    else $error("dark common on an rpm step");

endmodule

bind seven_segment_scan_multiplexer_core sssm_checker u_sssm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

@@ test/tb_seven_segment_scan_multiplexer_core.sv @@
// Testbench for seven_segment_scan_multiplexer_core: directed and random requests with
// random idling on both sides, checked against a predictor of the scan outputs.
// Depends on sssm_pkg and the RTL under src.
`timescale 1ns / 1ps
module tb_seven_segment_scan_multiplexer_core;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SEGMENT_ITEMS = 235;

  class segment_scan_predictor;
    logic [7:0] counter_lut [10] = '{8'd129, 8'd243, 8'd73, 8'd97, 8'd51,
                                     8'd37, 8'd5, 8'd241, 8'd1, 8'd33};
    logic [7:0] rpm_lut_a [10] = '{8'd3, 8'd111, 8'd133, 8'd37, 8'd105,
                                   8'd49, 8'd17, 8'd103, 8'd1, 8'd33};
    logic [7:0] rpm_lut_b [10] = '{8'd17, 8'd221, 8'd41, 8'd137, 8'd197,
                                   8'd131, 8'd3, 8'd217, 8'd1, 8'd129};
    logic [7:0] digit_bytes [8];
    logic [2:0] scan_pos;
    logic point_on;
    logic blink_on;
    sssm_pkg::out_item_t pending_scans [$];
    int mismatch_count;

    function new();
      foreach (digit_bytes[i]) digit_bytes[i] = 8'h00;
      scan_pos = 3'd0;
      point_on = 1'b0;
      blink_on = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic idx, logic val);
      if (idx == sssm_pkg::CFG_POINT_ENABLE) point_on = val;
      else blink_on = val;
    endfunction

    function void split_decimal(int unsigned v, output int unsigned d [4]);
      if (v > 9999) v = 9999;
      d[0] = v / 1000;
      d[1] = (v % 1000) / 100;
      d[2] = (v % 100) / 10;
      d[3] = v % 10;
    endfunction

    function void note_request(sssm_pkg::in_item_t req);
      int unsigned d [4];
      sssm_pkg::out_item_t res;
      logic [7:0] pat;
      case (req.cmd)
        sssm_pkg::CMD_SET_COUNTER: begin
          split_decimal(int'(req.minutes) * 100 + int'(req.seconds), d);
          for (int i = 0; i < 4; i++) digit_bytes[i] = counter_lut[d[i]];
        end
        sssm_pkg::CMD_SET_RPM: begin
          split_decimal(req.rpm_value[15] ? 0 : int'(req.rpm_value[14:0]), d);
          digit_bytes[4] = rpm_lut_a[d[0]];
          digit_bytes[5] = rpm_lut_b[d[1]];
          digit_bytes[6] = rpm_lut_a[d[2]];
          digit_bytes[7] = rpm_lut_b[d[3]];
        end
        sssm_pkg::CMD_SCAN: begin
          if (scan_pos < 3'd4) begin
            pat = digit_bytes[scan_pos];
            if (point_on && scan_pos >= 3'd2) pat = pat & sssm_pkg::POINT_MASK;
            res.first_byte = pat;
            res.second_byte = sssm_pkg::BLANK_BYTE;
            res.common_lit = !(blink_on && req.blink_phase > sssm_pkg::BLINK_HALF);
          end else begin
            res.first_byte = sssm_pkg::BLANK_BYTE;
            res.second_byte = digit_bytes[scan_pos];
            res.common_lit = 1'b1;
          end
          res.common_released = 2'(scan_pos + 3'd3);
          res.common_driven = scan_pos[1:0];
          pending_scans.push_back(res);
          scan_pos = scan_pos + 3'd1;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        mismatch_count++;
      end
    endfunction

    function void check_scan(sssm_pkg::out_item_t got);
      sssm_pkg::out_item_t exp_item;
      if (pending_scans.size() == 0) begin
        $error("scan result with none pending: %h", got);
        mismatch_count++;
        return;
      end
      exp_item = pending_scans.pop_front();
      compare_field("first_byte", exp_item.first_byte, got.first_byte);
      compare_field("second_byte", exp_item.second_byte, got.second_byte);
      compare_field("common_released", exp_item.common_released, got.common_released);
      compare_field("common_driven", exp_item.common_driven, got.common_driven);
      compare_field("common_lit", exp_item.common_lit, got.common_lit);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sssm_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sssm_pkg::out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic cfg_data_i = 1'b0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  segment_scan_predictor predictor = new();

  seven_segment_scan_multiplexer_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("seven_segment_scan_multiplexer_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predictor.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) predictor.check_scan(out_data_o);
    end
  end

  function automatic sssm_pkg::in_item_t make_request(logic [1:0] cmd,
                                                      logic [7:0] minutes,
                                                      logic [7:0] seconds,
                                                      logic [15:0] rpm,
                                                      logic [8:0] phase);
    sssm_pkg::in_item_t r;
    r.cmd = cmd;
    r.minutes = minutes;
    r.seconds = seconds;
    r.rpm_value = rpm;
    r.blink_phase = phase;
    return r;
  endfunction

  function automatic sssm_pkg::in_item_t random_request();
    sssm_pkg::in_item_t r;
    int pick;
    r = make_request(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                     9'($urandom));
    pick = $urandom_range(99);
    if (pick < 12) r.cmd = sssm_pkg::CMD_SET_COUNTER;
    else if (pick < 24) r.cmd = sssm_pkg::CMD_SET_RPM;
    else if (pick < 94) r.cmd = sssm_pkg::CMD_SCAN;
    else r.cmd = sssm_pkg::CMD_UNUSED;
    if ($urandom_range(2) == 0) begin
      r.minutes = 8'($urandom_range(99));
      r.seconds = 8'($urandom_range(59));
    end
    case ($urandom_range(3))
      0: r.rpm_value = 16'($urandom_range(9999));
      1: r.rpm_value = 16'($urandom_range(9990, 10010));
      2: r.rpm_value = 16'(int'($urandom_range(4)) - 2);
      default: ;
    endcase
    case ($urandom_range(2))
      0: r.blink_phase = 9'($urandom_range(245, 256));
      1: r.blink_phase = 9'($urandom_range(499));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(sssm_pkg::in_item_t req);
    int gap;
    in_data_i <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (predictor.pending_scans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic idx, logic val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predictor.set_register(idx, val);
  endtask

  initial begin : stimulus
    sssm_pkg::in_item_t req;
    int sent;
    int mode;
    logic [8:0] phases [8] = '{9'd0, 9'd250, 9'd251, 9'd499, 9'd500, 9'd511, 9'd250, 9'd251};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(sssm_pkg::CFG_POINT_ENABLE, 1'b1);
    write_config(sssm_pkg::CFG_BLINK_ENABLE, 1'b1);
    send_request(make_request(sssm_pkg::CMD_SET_COUNTER, 8'd0, 8'd0, 16'h0000, 9'd0));
    send_request(make_request(sssm_pkg::CMD_SET_COUNTER, 8'd255, 8'd255, 16'hFFFF, 9'd511));
    send_request(make_request(sssm_pkg::CMD_SET_RPM, 8'd0, 8'd0, 16'h8000, 9'd0));
    send_request(make_request(sssm_pkg::CMD_SET_RPM, 8'd255, 8'd255, 16'h7FFF, 9'd511));
    send_request(make_request(sssm_pkg::CMD_SET_COUNTER, 8'd99, 8'd99, 16'hFFFF, 9'd0));
    send_request(make_request(sssm_pkg::CMD_SET_RPM, 8'd0, 8'd0, 16'd9999, 9'd0));
    send_request(make_request(sssm_pkg::CMD_UNUSED, 8'hA5, 8'h5A, 16'h1234, 9'h155));
    for (int i = 0; i < 8; i++)
      send_request(make_request(sssm_pkg::CMD_SCAN, 8'hFF, 8'h00, 16'hFFFF, phases[i]));
    send_request(make_request(sssm_pkg::CMD_SET_COUNTER, 8'd12, 8'd34, 16'd0, 9'd0));
    send_request(make_request(sssm_pkg::CMD_SET_RPM, 8'd0, 8'd0, 16'd5678, 9'd0));
    send_request(make_request(sssm_pkg::CMD_SET_RPM, 8'd0, 8'd0, 16'd10000, 9'd0));
    for (int i = 0; i < 8; i++)
      send_request(make_request(sssm_pkg::CMD_SCAN, 8'h00, 8'hFF, 16'h0000, phases[7 - i]));

    for (int seg = 0; seg < 8; seg++) begin
      in_valid_i <= 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_config(sssm_pkg::CFG_POINT_ENABLE, seg[1]);
      write_config(sssm_pkg::CFG_BLINK_ENABLE, seg[2]);
      mode = seg % 4;
      sender_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 29 : 0;
      receiver_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 29 : 0;
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        req = random_request();
        send_request(req);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    wait_idle();
    if (predictor.mismatch_count == 0 && predictor.pending_scans.size() == 0)
      $display("seven_segment_scan_multiplexer_core: match");
    else
      $display("seven_segment_scan_multiplexer_core: mismatch");
    $finish;
  end
endmodule
